// ===== sv/jmcc_pkg.sv =====
// ---------------------------------------------------------------------------
// jmcc_pkg
// shared types, widths, codes and colour conversion constants
// ---------------------------------------------------------------------------
package jmcc_pkg;

   // payload widths
   localparam int OP_W     = 1;
   localparam int BLOCK_W  = 4;
   localparam int INDEX_W  = 6;
   localparam int SAMPLE_W = 8;
   localparam int PIX_W    = 5;
   localparam int COLOR_W  = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
   localparam logic [OP_W-1:0] OP_CONVERT = 1'b1;

   // register map, word index (byte address / 4)
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_SAMPLING_SHIFTS    = 3'd0;
   localparam logic [2:0] REG_LUMA_FIRST_BLOCK   = 3'd1;
   localparam logic [2:0] REG_CB_FIRST_BLOCK     = 3'd2;
   localparam logic [2:0] REG_CR_FIRST_BLOCK     = 3'd3;
   localparam logic [2:0] REG_LUMA_BLOCKS_ACROSS = 3'd4;
   localparam logic [2:0] REG_CB_BLOCKS_ACROSS   = 3'd5;
   localparam logic [2:0] REG_CR_BLOCKS_ACROSS   = 3'd6;

   localparam int SHIFTS_W = 12;
   localparam int ACROSS_W = 3;

   // component numbers
   localparam int COMP_Y  = 0;
   localparam int COMP_CB = 1;
   localparam int COMP_CR = 2;
   localparam int COMPS   = 3;

   // fixed-point coefficients and their shifts
   localparam int COEF_CR_R   = 359;
   localparam int SHIFT_CR_R  = 8;
   localparam int COEF_CB_G   = 11;
   localparam int SHIFT_CB_G  = 5;
   localparam int COEF_CR_G   = 183;
   localparam int SHIFT_CR_G  = 8;
   localparam int COEF_CB_B   = 227;
   localparam int SHIFT_CB_B  = 7;
   localparam int CHROMA_BIAS = 128;
   localparam int PIXEL_MAX   = 255;

   typedef logic signed [11:0] sum_type;
   typedef logic signed [17:0] prod_type;

   function automatic logic [COLOR_W-1:0] clamp_byte(input sum_type v);
      logic [COLOR_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > sum_type'(PIXEL_MAX)) begin
         res = COLOR_W'(PIXEL_MAX);
      end else begin
         res = v[COLOR_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== sv/jmcc_if.sv =====
// ---------------------------------------------------------------------------
// jmcc channel interfaces
// request channel (sample loads and pixel converts) and pixel result channel
// ---------------------------------------------------------------------------
interface jmcc_req_if;
   logic                              valid;
   logic                              ready;
   logic [jmcc_pkg::OP_W-1:0]         operation;
   logic [jmcc_pkg::BLOCK_W-1:0]      block_number;
   logic [jmcc_pkg::INDEX_W-1:0]      sample_index;
   logic [jmcc_pkg::SAMPLE_W-1:0]     sample_value;
   logic [jmcc_pkg::PIX_W-1:0]        pixel_row;
   logic [jmcc_pkg::PIX_W-1:0]        pixel_col;

   modport source (output valid, operation, block_number, sample_index, sample_value,
                   pixel_row, pixel_col, input ready);
   modport sink   (input valid, operation, block_number, sample_index, sample_value,
                   pixel_row, pixel_col, output ready);
endinterface

interface jmcc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [jmcc_pkg::COLOR_W-1:0]      red;
   logic [jmcc_pkg::COLOR_W-1:0]      green;
   logic [jmcc_pkg::COLOR_W-1:0]      blue;
   logic [jmcc_pkg::PIX_W-1:0]        out_row;
   logic [jmcc_pkg::PIX_W-1:0]        out_col;

   modport source (output valid, red, green, blue, out_row, out_col, input ready);
   modport sink   (input valid, red, green, blue, out_row, out_col, output ready);
endinterface

// ===== sv/jmcc_sample_ram.sv =====
// ---------------------------------------------------------------------------
// jmcc_sample_ram
// one copy of the mcu sample store, one write and one registered read port
// ---------------------------------------------------------------------------
module jmcc_sample_ram #(
   parameter int DEPTH  = 640,
   parameter int ADDR_W = 10
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADDR_W-1:0]                 wr_addr,
   input  logic [jmcc_pkg::SAMPLE_W-1:0]     wr_data,
   input  logic                              rd_en,
   input  logic [ADDR_W-1:0]                 rd_addr,
   output logic [jmcc_pkg::SAMPLE_W-1:0]     rd_data
);

   logic [jmcc_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [jmcc_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/jpeg_mcu_color_upsample_convert_core.sv =====
// ---------------------------------------------------------------------------
// jpeg_mcu_color_upsample_convert_core
// mcu sample store with upsampled ycbcr to rgb conversion; unless rsp stalls, one pixel per cycle
// ---------------------------------------------------------------------------
// path: a convert transfer passes the registered store read in stage 1, then the result slot, which drives rsp
// throughput: one request per cycle, loads and converts alike, while rsp does not stall; set by the
//   three sample store copies, each with one read port and one write port on a shared load address
// reset: registers return to their reset values, pipeline and result slot empty;
//   the sample store is not cleared and holds garbage until loaded
// ---------------------------------------------------------------------------
module jpeg_mcu_color_upsample_convert_core #(
   parameter int MCU_BLOCKS   = 10,
   parameter int MAX_MCU_SIDE = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   jmcc_req_if.sink                              req_chan,
   jmcc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [jmcc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [jmcc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [jmcc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int BLK_W  = $clog2(MCU_BLOCKS);
   localparam int ADDR_W = BLK_W + jmcc_pkg::INDEX_W;
   localparam int DEPTH  = MCU_BLOCKS * 64;
   localparam int BIDX_W = 6;   // first + across*3 + 3 stays below 64

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   logic [jmcc_pkg::SHIFTS_W-1:0] shifts_ff;
   logic [jmcc_pkg::BLOCK_W-1:0]  first_ff  [jmcc_pkg::COMPS];
   logic [jmcc_pkg::ACROSS_W-1:0] across_ff [jmcc_pkg::COMPS];
   logic                          csr_write;
   logic [2:0]                    csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_reg    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         shifts_ff                   <= '0;
         first_ff[jmcc_pkg::COMP_Y]  <= 4'd0;
         first_ff[jmcc_pkg::COMP_CB] <= 4'd1;
         first_ff[jmcc_pkg::COMP_CR] <= 4'd2;
         across_ff[jmcc_pkg::COMP_Y]  <= 3'd1;
         across_ff[jmcc_pkg::COMP_CB] <= 3'd1;
         across_ff[jmcc_pkg::COMP_CR] <= 3'd1;
      end else if (csr_write) begin
         unique case (csr_reg)
            jmcc_pkg::REG_SAMPLING_SHIFTS: begin
               shifts_ff <= csr_pwdata[jmcc_pkg::SHIFTS_W-1:0];
            end
            jmcc_pkg::REG_LUMA_FIRST_BLOCK: begin
               first_ff[jmcc_pkg::COMP_Y] <= csr_pwdata[jmcc_pkg::BLOCK_W-1:0];
            end
            jmcc_pkg::REG_CB_FIRST_BLOCK: begin
               first_ff[jmcc_pkg::COMP_CB] <= csr_pwdata[jmcc_pkg::BLOCK_W-1:0];
            end
            jmcc_pkg::REG_CR_FIRST_BLOCK: begin
               first_ff[jmcc_pkg::COMP_CR] <= csr_pwdata[jmcc_pkg::BLOCK_W-1:0];
            end
            jmcc_pkg::REG_LUMA_BLOCKS_ACROSS: begin
               across_ff[jmcc_pkg::COMP_Y] <= csr_pwdata[jmcc_pkg::ACROSS_W-1:0];
            end
            jmcc_pkg::REG_CB_BLOCKS_ACROSS: begin
               across_ff[jmcc_pkg::COMP_CB] <= csr_pwdata[jmcc_pkg::ACROSS_W-1:0];
            end
            jmcc_pkg::REG_CR_BLOCKS_ACROSS: begin
               across_ff[jmcc_pkg::COMP_CR] <= csr_pwdata[jmcc_pkg::ACROSS_W-1:0];
            end
            default: begin
               // unmapped word, write dropped
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_reg)
         jmcc_pkg::REG_SAMPLING_SHIFTS:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(shifts_ff);
         jmcc_pkg::REG_LUMA_FIRST_BLOCK:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(first_ff[jmcc_pkg::COMP_Y]);
         jmcc_pkg::REG_CB_FIRST_BLOCK:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(first_ff[jmcc_pkg::COMP_CB]);
         jmcc_pkg::REG_CR_FIRST_BLOCK:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(first_ff[jmcc_pkg::COMP_CR]);
         jmcc_pkg::REG_LUMA_BLOCKS_ACROSS:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(across_ff[jmcc_pkg::COMP_Y]);
         jmcc_pkg::REG_CB_BLOCKS_ACROSS:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(across_ff[jmcc_pkg::COMP_CB]);
         jmcc_pkg::REG_CR_BLOCKS_ACROSS:
            csr_prdata = jmcc_pkg::CSR_DATA_W'(across_ff[jmcc_pkg::COMP_CR]);
         default:
            csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // pipeline flow control
   // stage 1 holds the registered store reads, the result slot feeds rsp
   // -------------------------------------------------------------------------
   logic out_valid_ff, out_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_free, s1_free;
   logic req_xfer, load_xfer, conv_xfer;
   logic pix_inside, load_inside;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free;
   assign req_xfer  = req_chan.valid & s1_free;

   // a pixel outside the mcu, or a load to a missing block, does nothing
   assign pix_inside  = ({1'b0, req_chan.pixel_row} < (jmcc_pkg::PIX_W+1)'(MAX_MCU_SIDE))
                     && ({1'b0, req_chan.pixel_col} < (jmcc_pkg::PIX_W+1)'(MAX_MCU_SIDE));
   assign load_inside = {1'b0, req_chan.block_number} < (jmcc_pkg::BLOCK_W+1)'(MCU_BLOCKS);

   assign load_xfer = req_xfer && (req_chan.operation == jmcc_pkg::OP_LOAD) && load_inside;
   assign conv_xfer = req_xfer && (req_chan.operation == jmcc_pkg::OP_CONVERT) && pix_inside;

   // load address, shared by all three store copies
   logic [ADDR_W-1:0] wr_addr;
   assign wr_addr = {req_chan.block_number[BLK_W-1:0], req_chan.sample_index};

   // -------------------------------------------------------------------------
   // per component address generation and store copy
   // -------------------------------------------------------------------------
   logic [jmcc_pkg::SAMPLE_W-1:0] smp       [jmcc_pkg::COMPS];
   logic [jmcc_pkg::COMPS-1:0]    blk_ok;
   logic [jmcc_pkg::COMPS-1:0]    s1_blk_ok_ff, s1_blk_ok_in;

   for (genvar k = 0; k < jmcc_pkg::COMPS; k++) begin : g_comp
      logic [1:0]               vshift, hshift;
      logic [jmcc_pkg::PIX_W-1:0] row_sh, col_sh;
      logic [BIDX_W-1:0]        blk;
      logic [ADDR_W-1:0]        rd_addr;

      assign vshift = shifts_ff[4*k+1 : 4*k];
      assign hshift = shifts_ff[4*k+3 : 4*k+2];
      assign row_sh = req_chan.pixel_row >> vshift;
      assign col_sh = req_chan.pixel_col >> hshift;

      // first + across * block row + block column
      assign blk = BIDX_W'(first_ff[k])
                 + BIDX_W'(BIDX_W'(across_ff[k]) * BIDX_W'(row_sh[4:3]))
                 + BIDX_W'(col_sh[4:3]);
      assign blk_ok[k] = blk < BIDX_W'(MCU_BLOCKS);
      assign rd_addr   = {blk[BLK_W-1:0], row_sh[2:0], col_sh[2:0]};

      jmcc_sample_ram #(
         .DEPTH  (DEPTH),
         .ADDR_W (ADDR_W)
      ) u_store (
         .clock   (clock),
         .wr_en   (load_xfer),
         .wr_addr (wr_addr),
         .wr_data (req_chan.sample_value),
         .rd_en   (conv_xfer && blk_ok[k]),
         .rd_addr (rd_addr),
         .rd_data (smp[k])
      );
   end

   // -------------------------------------------------------------------------
   // stage 1 control and pixel position
   // -------------------------------------------------------------------------
   logic [jmcc_pkg::PIX_W-1:0] s1_row_ff, s1_row_in;
   logic [jmcc_pkg::PIX_W-1:0] s1_col_ff, s1_col_in;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_row_in    = s1_row_ff;
      s1_col_in    = s1_col_ff;
      s1_blk_ok_in = s1_blk_ok_ff;
      if (s1_free) begin
         s1_valid_in = conv_xfer;
      end
      if (conv_xfer) begin
         s1_row_in    = req_chan.pixel_row;
         s1_col_in    = req_chan.pixel_col;
         s1_blk_ok_in = blk_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s1_blk_ok_ff <= s1_blk_ok_in;
   end

   // -------------------------------------------------------------------------
   // colour conversion on the registered samples
   // a block index past the store reads as a zero sample
   // -------------------------------------------------------------------------
   logic signed [9:0]   y_s, cb_s, cr_s;
   jmcc_pkg::prod_type  p_cr_r, p_cb_g, p_cr_g, p_cb_b;
   jmcc_pkg::prod_type  t_cr_r, t_cb_g, t_cr_g, t_cb_b;
   jmcc_pkg::sum_type   r_sum, g_sum, b_sum;
   logic [jmcc_pkg::SAMPLE_W-1:0] y_raw, cb_raw, cr_raw;

   assign y_raw  = s1_blk_ok_ff[jmcc_pkg::COMP_Y]  ? smp[jmcc_pkg::COMP_Y]  : '0;
   assign cb_raw = s1_blk_ok_ff[jmcc_pkg::COMP_CB] ? smp[jmcc_pkg::COMP_CB] : '0;
   assign cr_raw = s1_blk_ok_ff[jmcc_pkg::COMP_CR] ? smp[jmcc_pkg::COMP_CR] : '0;

   assign y_s  = $signed({2'b00, y_raw});
   assign cb_s = $signed({2'b00, cb_raw}) - $signed(10'(jmcc_pkg::CHROMA_BIAS));
   assign cr_s = $signed({2'b00, cr_raw}) - $signed(10'(jmcc_pkg::CHROMA_BIAS));

   assign p_cr_r = 18'(cr_s) * $signed(18'(jmcc_pkg::COEF_CR_R));
   assign p_cb_g = 18'(cb_s) * $signed(18'(jmcc_pkg::COEF_CB_G));
   assign p_cr_g = 18'(cr_s) * $signed(18'(jmcc_pkg::COEF_CR_G));
   assign p_cb_b = 18'(cb_s) * $signed(18'(jmcc_pkg::COEF_CB_B));

   // arithmetic shifts round towards minus infinity
   assign t_cr_r = p_cr_r >>> jmcc_pkg::SHIFT_CR_R;
   assign t_cb_g = p_cb_g >>> jmcc_pkg::SHIFT_CB_G;
   assign t_cr_g = p_cr_g >>> jmcc_pkg::SHIFT_CR_G;
   assign t_cb_b = p_cb_b >>> jmcc_pkg::SHIFT_CB_B;

   assign r_sum = jmcc_pkg::sum_type'(y_s) + jmcc_pkg::sum_type'(t_cr_r);
   assign g_sum = jmcc_pkg::sum_type'(y_s) - jmcc_pkg::sum_type'(t_cb_g)
                - jmcc_pkg::sum_type'(t_cr_g);
   assign b_sum = jmcc_pkg::sum_type'(y_s) + jmcc_pkg::sum_type'(t_cb_b);

   // -------------------------------------------------------------------------
   // result slot
   // -------------------------------------------------------------------------
   logic [jmcc_pkg::COLOR_W-1:0] red_ff, red_in;
   logic [jmcc_pkg::COLOR_W-1:0] green_ff, green_in;
   logic [jmcc_pkg::COLOR_W-1:0] blue_ff, blue_in;
   logic [jmcc_pkg::PIX_W-1:0]   out_row_ff, out_row_in;
   logic [jmcc_pkg::PIX_W-1:0]   out_col_ff, out_col_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            red_in     = jmcc_pkg::clamp_byte(r_sum);
            green_in   = jmcc_pkg::clamp_byte(g_sum);
            blue_in    = jmcc_pkg::clamp_byte(b_sum);
            out_row_in = s1_row_ff;
            out_col_in = s1_col_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff     <= red_in;
      green_ff   <= green_in;
      blue_ff    <= blue_in;
      out_row_ff <= out_row_in;
      out_col_ff <= out_col_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.red     = red_ff;
   assign rsp_chan.green   = green_ff;
   assign rsp_chan.blue    = blue_ff;
   assign rsp_chan.out_row = out_row_ff;
   assign rsp_chan.out_col = out_col_ff;

endmodule

// ===== tb/jpeg_mcu_color_upsample_convert_core_test.sv =====
// ---------------------------------------------------------------------------
// jpeg_mcu_color_upsample_convert_core_test
// self-checking bench: sample loads and pixel converts against a local
// colour conversion predictor, over several sampling and block layouts
// ---------------------------------------------------------------------------
module jpeg_mcu_color_upsample_convert_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MCU_BLOCKS     = 10;
   localparam int MAX_MCU_SIDE   = 32;
   localparam int BLOCK_SAMPLES  = 64;
   localparam int STORE_ENTRIES  = MCU_BLOCKS * BLOCK_SAMPLES;
   localparam int SETTLE_CYCLES  = 4;      // a convert passes stage 1 and the result slot before leaving rsp
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 150;
   localparam int STEADY_PHASE   = 3;      // phase run with no idling on either side
   localparam logic [2:0] REG_UNUSED = 3'd7;  // address past the last register

   // one request as driven on req
   typedef struct packed {
      logic [jmcc_pkg::OP_W-1:0]     op;
      logic [jmcc_pkg::BLOCK_W-1:0]  block;
      logic [jmcc_pkg::INDEX_W-1:0]  index;
      logic [jmcc_pkg::SAMPLE_W-1:0] value;
      logic [jmcc_pkg::PIX_W-1:0]    row;
      logic [jmcc_pkg::PIX_W-1:0]    col;
   } request_type;

   localparam int REQUEST_W = $bits(request_type);

   // one converted pixel as seen on rsp
   typedef struct packed {
      logic [jmcc_pkg::COLOR_W-1:0] red;
      logic [jmcc_pkg::COLOR_W-1:0] green;
      logic [jmcc_pkg::COLOR_W-1:0] blue;
      logic [jmcc_pkg::PIX_W-1:0]   row;
      logic [jmcc_pkg::PIX_W-1:0]   col;
   } pixel_type;

   logic clock;
   logic reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [jmcc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [jmcc_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [jmcc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   jmcc_req_if req_bus ();
   jmcc_rsp_if rsp_bus ();

   jpeg_mcu_color_upsample_convert_core #(
      .MCU_BLOCKS   (MCU_BLOCKS),
      .MAX_MCU_SIDE (MAX_MCU_SIDE)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -----------------------------------------------------------------------
   // predictor state: its own copy of the mcu store and the registers
   // -----------------------------------------------------------------------
   logic [jmcc_pkg::SAMPLE_W-1:0] sample_mem [STORE_ENTRIES];
   bit                            loaded     [STORE_ENTRIES];   // entry written since reset
   logic [jmcc_pkg::SHIFTS_W-1:0] cfg_shifts;
   logic [jmcc_pkg::BLOCK_W-1:0]  cfg_first  [jmcc_pkg::COMPS];
   logic [jmcc_pkg::ACROSS_W-1:0] cfg_across [jmcc_pkg::COMPS];

   pixel_type pixel_queue [$];  // converted pixels still owed by the block
   int        requests_taken;   // transfers that load or convert, ignored loads excluded
   int        mismatches;
   bit        no_gaps;          // suppresses idling on both sides
   pixel_type seen_pixel;
   pixel_type want_pixel;

   // -----------------------------------------------------------------------
   // clock, run limit
   // -----------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // -----------------------------------------------------------------------
   // prediction
   // -----------------------------------------------------------------------

   // store entry a component reads for a pixel, or -1 when the block index
   // lands past the store (the block then reads a zero sample)
   function automatic int sample_slot(input int comp, input int row, input int col);
      int vs;
      int hs;
      int r;
      int c;
      int blk;
      vs  = int'(cfg_shifts[comp*4 +: 2]);
      hs  = int'(cfg_shifts[comp*4 + 2 +: 2]);
      r   = row >> vs;
      c   = col >> hs;
      blk = int'(cfg_first[comp]) + int'(cfg_across[comp]) * (r >> 3) + (c >> 3);
      if (blk >= MCU_BLOCKS) begin
         return -1;
      end
      return blk * BLOCK_SAMPLES + (r & 7) * 8 + (c & 7);
   endfunction

   function automatic int component_sample(input int comp, input int row, input int col);
      int slot;
      slot = sample_slot(comp, row, col);
      return (slot < 0) ? 0 : int'(sample_mem[slot]);
   endfunction

   function automatic logic [jmcc_pkg::COLOR_W-1:0] saturate_colour(input int level);
      if (level < 0) begin
         return '0;
      end
      if (level > jmcc_pkg::PIXEL_MAX) begin
         return jmcc_pkg::COLOR_W'(jmcc_pkg::PIXEL_MAX);
      end
      return jmcc_pkg::COLOR_W'(level);
   endfunction

   // ycbcr to rgb with floor shifts; >>> on a signed int rounds towards minus infinity
   function automatic pixel_type predict_pixel(input int row, input int col);
      int        luma;
      int        cb;
      int        cr;
      pixel_type px;
      luma = component_sample(jmcc_pkg::COMP_Y, row, col);
      cb   = component_sample(jmcc_pkg::COMP_CB, row, col) - jmcc_pkg::CHROMA_BIAS;
      cr   = component_sample(jmcc_pkg::COMP_CR, row, col) - jmcc_pkg::CHROMA_BIAS;
      px.red   = saturate_colour(luma
                    + ((jmcc_pkg::COEF_CR_R * cr) >>> jmcc_pkg::SHIFT_CR_R));
      px.green = saturate_colour(luma
                    - ((jmcc_pkg::COEF_CB_G * cb) >>> jmcc_pkg::SHIFT_CB_G)
                    - ((jmcc_pkg::COEF_CR_G * cr) >>> jmcc_pkg::SHIFT_CR_G));
      px.blue  = saturate_colour(luma
                    + ((jmcc_pkg::COEF_CB_B * cb) >>> jmcc_pkg::SHIFT_CB_B));
      px.row   = jmcc_pkg::PIX_W'(row);
      px.col   = jmcc_pkg::PIX_W'(col);
      return px;
   endfunction

   function automatic void note_problem(input string text);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s", text);
      end
   endfunction

   // -----------------------------------------------------------------------
   // result side: random stalls on rsp ready, every transfer checked
   // against the oldest owed pixel
   // -----------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = no_gaps || ($urandom_range(99) >= 8);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
         seen_pixel.red   = rsp_bus.red;
         seen_pixel.green = rsp_bus.green;
         seen_pixel.blue  = rsp_bus.blue;
         seen_pixel.row   = rsp_bus.out_row;
         seen_pixel.col   = rsp_bus.out_col;
         if (pixel_queue.size() == 0) begin
            note_problem($sformatf("unexpected pixel r=%0d g=%0d b=%0d at (%0d,%0d)",
               seen_pixel.red, seen_pixel.green, seen_pixel.blue,
               seen_pixel.row, seen_pixel.col));
         end else begin
            want_pixel = pixel_queue.pop_front();
            if (seen_pixel !== want_pixel) begin
               note_problem({
                  $sformatf("pixel mismatch: expected r=%0d g=%0d b=%0d at (%0d,%0d)",
                     want_pixel.red, want_pixel.green, want_pixel.blue,
                     want_pixel.row, want_pixel.col),
                  $sformatf(", got r=%0d g=%0d b=%0d at (%0d,%0d)",
                     seen_pixel.red, seen_pixel.green, seen_pixel.blue,
                     seen_pixel.row, seen_pixel.col)});
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // request side
   // -----------------------------------------------------------------------

   // drives one request from a falling edge, holds it until the transfer,
   // updates the predictor at that edge and returns on the next falling edge;
   // valid stays high so back-to-back requests need no gap
   task automatic send_request(input request_type item);
      while (!no_gaps && $urandom_range(99) < 8) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.operation    = item.op;
      req_bus.block_number = item.block;
      req_bus.sample_index = item.index;
      req_bus.sample_value = item.value;
      req_bus.pixel_row    = item.row;
      req_bus.pixel_col    = item.col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (item.op == jmcc_pkg::OP_LOAD) begin
         // loads to a block past the store are dropped by the block
         if (item.block < MCU_BLOCKS) begin
            sample_mem[item.block * BLOCK_SAMPLES + item.index] = item.value;
            loaded[item.block * BLOCK_SAMPLES + item.index]     = 1'b1;
            requests_taken++;
         end
      end else begin
         pixel_queue.push_back(predict_pixel(item.row, item.col));
         requests_taken++;
      end
      @(negedge clock);
   endtask

   // converts one pixel; any of its three samples not yet written is loaded
   // first, and a level of 0 or more forces that sample to the given value.
   // unused payload fields carry random bits
   task automatic fill_and_convert(input int row, input int col,
                                   input int y_level, input int cb_level,
                                   input int cr_level);
      request_type item;
      int          slot;
      int          levels [jmcc_pkg::COMPS];
      levels = '{y_level, cb_level, cr_level};
      for (int comp = 0; comp < jmcc_pkg::COMPS; comp++) begin
         slot = sample_slot(comp, row, col);
         if (slot >= 0 && (levels[comp] >= 0 || !loaded[slot])) begin
            item       = REQUEST_W'($urandom());
            item.op    = jmcc_pkg::OP_LOAD;
            item.block = jmcc_pkg::BLOCK_W'(slot / BLOCK_SAMPLES);
            item.index = jmcc_pkg::INDEX_W'(slot % BLOCK_SAMPLES);
            item.value = (levels[comp] >= 0) ? jmcc_pkg::SAMPLE_W'(levels[comp])
                                             : jmcc_pkg::SAMPLE_W'($urandom_range(255));
            send_request(item);
         end
      end
      item     = REQUEST_W'($urandom());
      item.op  = jmcc_pkg::OP_CONVERT;
      item.row = jmcc_pkg::PIX_W'(row);
      item.col = jmcc_pkg::PIX_W'(col);
      send_request(item);
   endtask

   // mostly complete pixels, some with fresh samples, and loose loads
   // that partly target blocks past the store
   task automatic run_traffic(input int count);
      int          goal;
      int          pick;
      request_type item;
      goal = requests_taken + count;
      while (requests_taken < goal) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            fill_and_convert($urandom_range(31), $urandom_range(31), -1, -1, -1);
         end else if (pick < 82) begin
            fill_and_convert($urandom_range(31), $urandom_range(31),
                             $urandom_range(255), $urandom_range(255), $urandom_range(255));
         end else begin
            item    = REQUEST_W'($urandom());
            item.op = jmcc_pkg::OP_LOAD;
            send_request(item);
         end
      end
   endtask

   // waits until every owed pixel has arrived and the pipeline has emptied
   task automatic drain_pipeline();
      req_bus.valid = 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // -----------------------------------------------------------------------
   // register port: setup then access, write taken at the access edge
   // -----------------------------------------------------------------------
   task automatic set_register(input logic [2:0] idx,
                               input logic [jmcc_pkg::CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = jmcc_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         jmcc_pkg::REG_SAMPLING_SHIFTS:
            cfg_shifts = value[jmcc_pkg::SHIFTS_W-1:0];
         jmcc_pkg::REG_LUMA_FIRST_BLOCK:
            cfg_first[jmcc_pkg::COMP_Y] = value[jmcc_pkg::BLOCK_W-1:0];
         jmcc_pkg::REG_CB_FIRST_BLOCK:
            cfg_first[jmcc_pkg::COMP_CB] = value[jmcc_pkg::BLOCK_W-1:0];
         jmcc_pkg::REG_CR_FIRST_BLOCK:
            cfg_first[jmcc_pkg::COMP_CR] = value[jmcc_pkg::BLOCK_W-1:0];
         jmcc_pkg::REG_LUMA_BLOCKS_ACROSS:
            cfg_across[jmcc_pkg::COMP_Y] = value[jmcc_pkg::ACROSS_W-1:0];
         jmcc_pkg::REG_CB_BLOCKS_ACROSS:
            cfg_across[jmcc_pkg::COMP_CB] = value[jmcc_pkg::ACROSS_W-1:0];
         jmcc_pkg::REG_CR_BLOCKS_ACROSS:
            cfg_across[jmcc_pkg::COMP_CR] = value[jmcc_pkg::ACROSS_W-1:0];
         default: ;   // no register here, nothing changes
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic apply_settings(input int shifts,
                                 input int first_y, input int first_cb, input int first_cr,
                                 input int across_y, input int across_cb, input int across_cr);
      drain_pipeline();
      set_register(jmcc_pkg::REG_SAMPLING_SHIFTS, jmcc_pkg::CSR_DATA_W'(shifts));
      set_register(jmcc_pkg::REG_LUMA_FIRST_BLOCK, jmcc_pkg::CSR_DATA_W'(first_y));
      set_register(jmcc_pkg::REG_CB_FIRST_BLOCK, jmcc_pkg::CSR_DATA_W'(first_cb));
      set_register(jmcc_pkg::REG_CR_FIRST_BLOCK, jmcc_pkg::CSR_DATA_W'(first_cr));
      set_register(jmcc_pkg::REG_LUMA_BLOCKS_ACROSS, jmcc_pkg::CSR_DATA_W'(across_y));
      set_register(jmcc_pkg::REG_CB_BLOCKS_ACROSS, jmcc_pkg::CSR_DATA_W'(across_cb));
      set_register(jmcc_pkg::REG_CR_BLOCKS_ACROSS, jmcc_pkg::CSR_DATA_W'(across_cr));
   endtask

   // -----------------------------------------------------------------------
   // tests
   // -----------------------------------------------------------------------

   // reset layout: corner pixels and one inner pixel with saturating and neutral samples, and
   // loads to blocks past the store, which must leave the store untouched
   task automatic test_directed_pixels();
      request_type item;
      item       = REQUEST_W'($urandom());
      item.op    = jmcc_pkg::OP_LOAD;
      item.block = 4'd10;
      item.index = '0;
      item.value = 8'hFF;
      send_request(item);
      item.block = 4'd15;
      item.index = 6'd63;
      item.value = 8'h00;
      send_request(item);
      fill_and_convert(0, 0, 255, 255, 255);
      fill_and_convert(31, 31, 0, 0, 0);
      fill_and_convert(0, 31, 128, 128, 128);
      fill_and_convert(31, 0, 255, 0, 255);
      fill_and_convert(15, 16, 0, 255, 0);
   endtask

   // extreme layouts: deepest subsampling, block indexes past the store,
   // a common 4:2:0 layout, zero blocks across, and a write to no register
   task automatic test_register_extremes();
      apply_settings(12'hFFF, 0, 1, 2, 4, 4, 4);
      run_traffic(60);
      apply_settings(0, 9, 9, 9, 4, 4, 4);
      fill_and_convert(31, 31, -1, -1, -1);
      run_traffic(60);
      apply_settings(12'h550, 0, 4, 5, 2, 1, 1);
      run_traffic(60);
      apply_settings(12'h00F, 9, 0, 0, 0, 0, 0);
      run_traffic(60);
      drain_pipeline();
      set_register(REG_UNUSED, $urandom());
      run_traffic(40);
   endtask

   // random layouts, one phase with no idling on either side
   task automatic test_random_settings();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings($urandom_range(4095),
                        $urandom_range(9), $urandom_range(9), $urandom_range(9),
                        $urandom_range(4), $urandom_range(4), $urandom_range(4));
         no_gaps = (phase == STEADY_PHASE);
         run_traffic(PHASE_REQUESTS);
      end
      no_gaps = 1'b0;
   endtask

   // -----------------------------------------------------------------------
   // main sequence
   // -----------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      no_gaps              = 1'b0;
      requests_taken       = 0;
      mismatches           = 0;
      req_bus.valid        = 1'b0;
      req_bus.operation    = jmcc_pkg::OP_LOAD;
      req_bus.block_number = '0;
      req_bus.sample_index = '0;
      req_bus.sample_value = '0;
      req_bus.pixel_row    = '0;
      req_bus.pixel_col    = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;

      // register reset values; the store starts unwritten
      cfg_shifts                    = '0;
      cfg_first[jmcc_pkg::COMP_Y]   = 4'd0;
      cfg_first[jmcc_pkg::COMP_CB]  = 4'd1;
      cfg_first[jmcc_pkg::COMP_CR]  = 4'd2;
      cfg_across[jmcc_pkg::COMP_Y]  = 3'd1;
      cfg_across[jmcc_pkg::COMP_CB] = 3'd1;
      cfg_across[jmcc_pkg::COMP_CR] = 3'd1;
      for (int i = 0; i < STORE_ENTRIES; i++) begin
         sample_mem[i] = '0;
         loaded[i]     = 1'b0;
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_pixels();
      test_register_extremes();
      test_random_settings();
      drain_pipeline();

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
